[rtl/core/strip_fingerprint_dual_crc_defines.svh]
// assertion macros for the strip fingerprint block
`ifndef STRIP_FINGERPRINT_DUAL_CRC_DEFINES_SVH
`define STRIP_FINGERPRINT_DUAL_CRC_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sfdc_pkg.sv]
// shared types, constants and crc functions for the strip fingerprint block
`timescale 1ns / 1ps

package sfdc_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] SEED_LOW   = 32'hFFFF_FFFF;
    localparam logic [31:0] SEED_HIGH  = 32'h1234_5678;
    localparam int unsigned ROT_SECOND = 29;
    localparam int unsigned ROT_FIRST  = 17;
    localparam logic [3:0]  TAIL_BYTES = 4'd4;

    typedef struct packed {
        logic        strip_first;
        logic [15:0] strip_col;
        logic [15:0] strip_row;
        logic [63:0] data_word;
        logic [3:0]  word_bytes;
        logic        row_end;
        logic        strip_end;
    } sfdc_item_t;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_TAIL,
        ACT_PAIR,
        ACT_LONE
    } sfdc_act_t;

    // reflected crc, bits taken lsb first
    function automatic logic [31:0] crc_feed64(input logic [31:0] crc, input logic [63:0] data);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < 64; i++)
        begin
            if (c[0] ^ data[i])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [31:0] crc_feed32(input logic [31:0] crc, input logic [31:0] data);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < 32; i++)
        begin
            if (c[0] ^ data[i])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

endpackage

[rtl/core/sfdc_in_reg.sv]
// input register stage holding one accepted item
`timescale 1ns / 1ps

module sfdc_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sfdc_pkg::sfdc_item_t in_item,
    input  logic                take,
    output logic                stage_valid,
    output sfdc_pkg::sfdc_item_t stage_item
);

    logic                 valid_reg;
    logic                 valid_next;
    sfdc_pkg::sfdc_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

[rtl/core/sfdc_lanes.sv]
// crc lane state and per-item update logic
`timescale 1ns / 1ps
`include "strip_fingerprint_dual_crc_defines.svh"

module sfdc_lanes (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  sfdc_pkg::sfdc_item_t item,
    output logic [63:0]          fp_next
);

    logic [31:0]         lo_reg;
    logic [31:0]         lo_next;
    logic [31:0]         hi_reg;
    logic [31:0]         hi_next;
    logic                hv_reg;
    logic                hv_next;
    logic [63:0]         held_reg;
    logic [31:0]         base_lo;
    logic [31:0]         base_hi;
    logic                hv_eff;
    logic [31:0]         lo_held;
    logic [31:0]         hi_held;
    sfdc_pkg::sfdc_act_t act;

    // a reseed drops any held word
    assign base_lo = item.strip_first ? (sfdc_pkg::SEED_LOW ^ {16'h0000, item.strip_col}) : lo_reg;
    assign base_hi = item.strip_first ? (sfdc_pkg::SEED_HIGH ^ {16'h0000, item.strip_row})
                                      : hi_reg;
    assign hv_eff  = hv_reg && !item.strip_first;

    assign lo_held = sfdc_pkg::crc_feed64(base_lo, held_reg);
    assign hi_held = sfdc_pkg::crc_feed64(base_hi,
                                          sfdc_pkg::rotl64(held_reg, sfdc_pkg::ROT_FIRST));

    always_comb
    begin
        if (item.word_bytes == sfdc_pkg::TAIL_BYTES)
            act = sfdc_pkg::ACT_TAIL;
        else if (hv_eff)
            act = sfdc_pkg::ACT_PAIR;
        else if (item.row_end || item.strip_end)
            act = sfdc_pkg::ACT_LONE;
        else
            act = sfdc_pkg::ACT_HOLD;
    end

    always_comb
    begin
        lo_next = base_lo;
        hi_next = base_hi;
        hv_next = 1'b0;
        case (act)
            sfdc_pkg::ACT_TAIL:
            begin
                // flush held word as lone, then four tail bytes unrotated
                lo_next = sfdc_pkg::crc_feed32(hv_eff ? lo_held : base_lo,
                                               item.data_word[31:0]);
                hi_next = sfdc_pkg::crc_feed32(hv_eff ? hi_held : base_hi,
                                               item.data_word[31:0]);
            end
            sfdc_pkg::ACT_PAIR:
            begin
                // high lane takes the second word first
                lo_next = sfdc_pkg::crc_feed64(lo_held, item.data_word);
                hi_next = sfdc_pkg::crc_feed64(
                    sfdc_pkg::crc_feed64(base_hi,
                        sfdc_pkg::rotl64(item.data_word, sfdc_pkg::ROT_SECOND)),
                    sfdc_pkg::rotl64(held_reg, sfdc_pkg::ROT_FIRST));
            end
            sfdc_pkg::ACT_LONE:
            begin
                lo_next = sfdc_pkg::crc_feed64(base_lo, item.data_word);
                hi_next = sfdc_pkg::crc_feed64(base_hi,
                    sfdc_pkg::rotl64(item.data_word, sfdc_pkg::ROT_FIRST));
            end
            sfdc_pkg::ACT_HOLD:
            begin
                hv_next = 1'b1;
            end
            default:
            begin
                hv_next = 1'b0;
            end
        endcase
    end

    assign fp_next = {lo_next, hi_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
            hv_reg <= 1'b0;
        end
        else if (advance)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            hv_reg <= hv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && act == sfdc_pkg::ACT_HOLD)
            held_reg <= item.data_word;
    end

    `SFDC_ASSERT_NEXT(a_strip_end_clears_held, advance && item.strip_end, !hv_reg, "word held past strip end")
    `SFDC_ASSERT_NEXT(a_idle_keeps_lanes, !advance, $stable(lo_reg) && $stable(hi_reg) && $stable(hv_reg), "lanes changed without an item")
    `SFDC_ASSERT_NOW(a_hold_leaves_lanes, act == sfdc_pkg::ACT_HOLD, lo_next == base_lo && hi_next == base_hi, "held word fed into a lane")

endmodule

[rtl/core/sfdc_out_reg.sv]
// result register holding one fingerprint until taken
`timescale 1ns / 1ps

module sfdc_out_reg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [63:0] load_data,
    output logic        slot_free,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] fingerprint
);

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] data_reg;

    assign slot_free  = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid   = valid_reg;
    assign fingerprint = data_reg;

endmodule

[rtl/core/strip_fingerprint_dual_crc.sv]
// an accepted item is held in the input register until it is taken
// taking it updates both lanes, and a strip-end item loads the result register
// in the same cycle; one item per cycle while no strip-end item waits for room
// a fingerprint waiting in the result register stalls only a strip-end item
// reset: rst_n clears both lanes, the held-word flag and both valid flags at once
`timescale 1ns / 1ps

module strip_fingerprint_dual_crc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        strip_first,
    input  logic [15:0] strip_col,
    input  logic [15:0] strip_row,
    input  logic [63:0] data_word,
    input  logic [3:0]  word_bytes,
    input  logic        row_end,
    input  logic        strip_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] fingerprint
);

    sfdc_pkg::sfdc_item_t in_item;
    sfdc_pkg::sfdc_item_t stage_item;
    logic                 stage_valid;
    logic                 take;
    logic                 slot_free;
    logic [63:0]          fp_next;

    assign in_item = '{strip_first: strip_first, strip_col: strip_col, strip_row: strip_row,
                       data_word: data_word, word_bytes: word_bytes, row_end: row_end,
                       strip_end: strip_end};

    // a strip-end item needs room in the result register
    assign take = stage_valid && (!stage_item.strip_end || slot_free);

    sfdc_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    sfdc_lanes u_lanes (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (take),
        .item    (stage_item),
        .fp_next (fp_next)
    );

    sfdc_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (take && stage_item.strip_end),
        .load_data   (fp_next),
        .slot_free   (slot_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fingerprint (fingerprint)
    );

endmodule

[tb/sv/strip_fingerprint_dual_crc_test.sv]
// self-checking testbench for the strip fingerprint block: directed table, random strips
`timescale 1ns / 1ps

module strip_fingerprint_dual_crc_test;

    localparam int RANDOM_ITEMS   = 530;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        sfdc_pkg::sfdc_item_t item;
        bit                   typed;
        logic [63:0]          fp;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        strip_first = 1'b0;
    logic [15:0] strip_col = '0;
    logic [15:0] strip_row = '0;
    logic [63:0] data_word = '0;
    logic [3:0]  word_bytes = 4'd8;
    logic        row_end = 1'b0;
    logic        strip_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [63:0] fingerprint;

    // predictor state
    logic [31:0] fp_low = '0;
    logic [31:0] fp_high = '0;
    logic [63:0] pend_word = '0;
    bit          pend_valid = 1'b0;

    logic [63:0]   pending_fingerprints[$];
    directed_row_t directed_rows[$];
    int            mismatch_count = 0;
    int            items_sent = 0;
    int            burst_left = 0;
    int            idle_cycles = 0;
    int            ready_cycle = 0;
    int            stall_left = 0;

    strip_fingerprint_dual_crc dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .strip_first (strip_first),
        .strip_col   (strip_col),
        .strip_row   (strip_row),
        .data_word   (data_word),
        .word_bytes  (word_bytes),
        .row_end     (row_end),
        .strip_end   (strip_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fingerprint (fingerprint)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // reflected crc over the low n bytes of w, lsb first
    function automatic logic [31:0] crc_bytes(input logic [31:0] c, input logic [63:0] w,
                                              input int n);
        logic [31:0] r;
        r = c;
        for (int b = 0; b < n; b++)
        begin
            r = r ^ {24'd0, w[8*b +: 8]};
            for (int k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ sfdc_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [63:0] rot_left64(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

    task automatic flush_pending();
        if (pend_valid)
        begin
            fp_low     = crc_bytes(fp_low, pend_word, 8);
            fp_high    = crc_bytes(fp_high, rot_left64(pend_word, sfdc_pkg::ROT_FIRST), 8);
            pend_valid = 1'b0;
            pend_word  = '0;
        end
    endtask

    task automatic predict_fingerprint(input sfdc_pkg::sfdc_item_t it, output bit emits,
                                       output logic [63:0] fp);
        if (it.strip_first)
        begin
            fp_low     = sfdc_pkg::SEED_LOW ^ {16'd0, it.strip_col};
            fp_high    = sfdc_pkg::SEED_HIGH ^ {16'd0, it.strip_row};
            pend_valid = 1'b0;
            pend_word  = '0;
        end
        if (it.word_bytes == sfdc_pkg::TAIL_BYTES)
        begin
            flush_pending();
            fp_low  = crc_bytes(fp_low, it.data_word, 4);
            fp_high = crc_bytes(fp_high, it.data_word, 4);
        end
        else if (pend_valid)
        begin
            fp_low     = crc_bytes(crc_bytes(fp_low, pend_word, 8), it.data_word, 8);
            // second word of the pair goes in first on the high lane
            fp_high    = crc_bytes(
                crc_bytes(fp_high, rot_left64(it.data_word, sfdc_pkg::ROT_SECOND), 8),
                rot_left64(pend_word, sfdc_pkg::ROT_FIRST), 8);
            pend_valid = 1'b0;
            pend_word  = '0;
        end
        else
        begin
            pend_word  = it.data_word;
            pend_valid = 1'b1;
        end
        if (it.row_end || it.strip_end)
            flush_pending();
        emits = it.strip_end;
        fp    = {fp_low, fp_high};
    endtask

    task automatic send_item(input sfdc_pkg::sfdc_item_t it, input bit typed,
                             input logic [63:0] typed_fp);
        bit          emits;
        logic [63:0] fp;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid    <= 1'b1;
        strip_first <= it.strip_first;
        strip_col   <= it.strip_col;
        strip_row   <= it.strip_row;
        data_word   <= it.data_word;
        word_bytes  <= it.word_bytes;
        row_end     <= it.row_end;
        strip_end   <= it.strip_end;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        predict_fingerprint(it, emits, fp);
        if (emits)
            pending_fingerprints.push_back(typed ? typed_fp : fp);
    endtask

    // hold the sender off until every fingerprint is out
    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_fingerprints.size() != 0);
    endtask

    task automatic add_row(input bit first, input logic [15:0] col, input logic [15:0] row,
                           input logic [63:0] word, input logic [3:0] nbytes,
                           input bit rend, input bit send, input bit typed,
                           input logic [63:0] fp);
        directed_row_t d;
        d.item.strip_first = first;
        d.item.strip_col   = col;
        d.item.strip_row   = row;
        d.item.data_word   = word;
        d.item.word_bytes  = nbytes;
        d.item.row_end     = rend;
        d.item.strip_end   = send;
        d.typed            = typed;
        d.fp               = fp;
        directed_rows.push_back(d);
    endtask

    function automatic logic [15:0] rand_index();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return {64{1'b1}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [3:0] rand_full_bytes();
        logic [3:0] n;
        if ($urandom_range(0, 6) != 0)
            return 4'd8;
        n = 4'($urandom);
        return (n == sfdc_pkg::TAIL_BYTES) ? 4'd8 : n;
    endfunction

    // one strip of rows, mostly well formed, with occasional broken framing
    task automatic send_strip();
        int                   rows;
        int                   words;
        int                   total;
        bit                   tail;
        bit                   reseed;
        sfdc_pkg::sfdc_item_t it;
        rows   = $urandom_range(1, 4);
        reseed = ($urandom_range(0, 9) != 0);
        for (int r = 0; r < rows; r++)
        begin
            words = $urandom_range(0, 5);
            tail  = ($urandom_range(0, 2) == 0);
            if (words == 0 && !tail)
                words = 1;
            total = words + int'(tail);
            for (int w = 0; w < total; w++)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    it.strip_first = 1'($urandom);
                    it.strip_col   = rand_index();
                    it.strip_row   = rand_index();
                    it.data_word   = rand_word();
                    it.word_bytes  = 4'($urandom);
                    it.row_end     = 1'($urandom);
                    it.strip_end   = ($urandom_range(0, 3) == 0);
                    send_item(it, 1'b0, '0);
                end
                it.strip_first = reseed && r == 0 && w == 0;
                it.strip_col   = rand_index();
                it.strip_row   = rand_index();
                it.data_word   = rand_word();
                if (tail && w == total - 1)
                    it.word_bytes = sfdc_pkg::TAIL_BYTES;
                else if ($urandom_range(0, 19) == 0)
                    it.word_bytes = sfdc_pkg::TAIL_BYTES;
                else
                    it.word_bytes = rand_full_bytes();
                it.row_end   = (w == total - 1) && ($urandom_range(0, 19) != 0);
                it.strip_end = (r == rows - 1) && (w == total - 1);
                send_item(it, 1'b0, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        logic ready_next;
        ready_cycle++;
        case ((ready_cycle / 100) % 4)
            0: ready_next = 1'b1;
            1: ready_next = ($urandom_range(0, 3) != 0);
            2: ready_next = ((ready_cycle % 7) < 4);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    ready_next = 1'b0;
                end
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                        stall_left = $urandom_range(3, 16);
                    ready_next = 1'b1;
                end
            end
        endcase
        out_ready <= ready_next;
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_fingerprints.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected fingerprint %h", $time, fingerprint);
                end
                else
                begin
                    want = pending_fingerprints.pop_front();
                    if (fingerprint !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: fingerprint expected %h actual %h",
                                 $time, want, fingerprint);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, %0d fingerprints outstanding",
                         $time, pending_fingerprints.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        // straight after reset the lanes are zero, so zero data keeps them zero
        add_row(0, 16'h0000, 16'h0000, 64'd0, 4'd8, 0, 1, 1, 64'd0);
        add_row(0, 16'h0000, 16'h0000, 64'd0, sfdc_pkg::TAIL_BYTES, 1, 1, 1, 64'd0);
        add_row(1, 16'h0000, 16'h0000, {64{1'b1}}, 4'd8, 0, 0, 0, '0);
        add_row(0, 16'h0000, 16'h0000, 64'h0123_4567_89AB_CDEF, 4'd8, 0, 0, 0, '0);
        add_row(0, 16'h0000, 16'h0000, 64'hA5A5_5A5A_F00F_0FF0, 4'd8, 1, 0, 0, '0);
        // row tail: upper half must be ignored
        add_row(0, 16'h0000, 16'h0000, 64'hFFFF_FFFF_DEAD_BEEF, sfdc_pkg::TAIL_BYTES,
                1, 0, 0, '0);
        add_row(0, 16'h0000, 16'h0000, 64'h1111_2222_3333_4444, 4'd8, 0, 0, 0, '0);
        // tail without row end flushes the held word, then pairing restarts
        add_row(0, 16'h0000, 16'h0000, 64'h0000_0000_8000_0001, sfdc_pkg::TAIL_BYTES,
                0, 0, 0, '0);
        add_row(0, 16'h0000, 16'h0000, 64'h8000_0000_0000_0001, 4'd8, 0, 0, 0, '0);
        add_row(0, 16'h0000, 16'h0000, 64'h7FFF_FFFF_FFFF_FFFE, 4'd8, 1, 0, 0, '0);
        add_row(0, 16'h0000, 16'h0000, 64'hCAFE_F00D_1234_5678, 4'd8, 0, 1, 0, '0);
        // no reseed after emit: col and row ignored, lanes carry on
        add_row(0, 16'hFFFF, 16'hFFFF, 64'h0F0F_0F0F_F0F0_F0F0, 4'd15, 0, 1, 0, '0);
        add_row(1, 16'hFFFF, 16'hFFFF, 64'h5555_AAAA_5555_AAAA, 4'd0, 0, 0, 0, '0);
        add_row(0, 16'h0000, 16'h0000, 64'hAAAA_5555_AAAA_5555, 4'd5, 1, 1, 0, '0);
        add_row(1, 16'h1234, 16'hABCD, 64'h0011_2233_4455_6677, 4'd7, 0, 1, 0, '0);
        // reseed mid strip drops the held word
        add_row(1, 16'h8000, 16'h0001, 64'h8899_AABB_CCDD_EEFF, 4'd3, 0, 0, 0, '0);
        add_row(1, 16'h0001, 16'h8000, 64'hFEDC_BA98_7654_3210, 4'd9, 0, 0, 0, '0);
        add_row(0, 16'h0000, 16'h0000, {64{1'b1}}, sfdc_pkg::TAIL_BYTES, 1, 1, 0, '0);
        add_row(1, 16'h7FFF, 16'hFFFE, {64{1'b1}}, 4'd8, 0, 0, 0, '0);
        add_row(0, 16'h0000, 16'h0000, 64'h0000_0000_FFFF_FFFF, sfdc_pkg::TAIL_BYTES,
                0, 1, 0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].fp);
        wait_drain();

        while (items_sent < directed_rows.size() + RANDOM_ITEMS)
        begin
            send_strip();
            if ($urandom_range(0, 19) == 0)
                wait_drain();
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_fingerprints.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
